### rtl/ofd_pkg.sv
package ofd_pkg;

  localparam int unsigned FrameBytes = 14;
  localparam int unsigned PosWidth   = $clog2(FrameBytes + 1);
  localparam int unsigned DivWidth   = 30;
  localparam int unsigned CntWidth   = $clog2(DivWidth);

  localparam logic [7:0]  HdrByte   = 8'hFE;
  localparam logic [7:0]  LenByte   = 8'h0A;
  localparam logic [7:0]  TailByte  = 8'h55;
  localparam logic [15:0] FlowScale = 16'd25600;

  typedef enum logic {
    OpByte = 1'b0,
    OpIdle = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDivX = 4'b0010,
    StDivY = 4'b0100,
    StDone = 4'b1000
  } state_e;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [DivWidth-1:0] dividend;
    logic [15:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

### rtl/ofd_div.sv
module ofd_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ofd_pkg::div_req_t req_i,
  output ofd_pkg::div_rsp_t rsp_o
);
  import ofd_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                neg_q, neg_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [15:0]         rem_q, rem_d;
  logic [DivWidth-1:0] quo_q, quo_d;
  logic [15:0]         dvs_q, dvs_d;
  logic [16:0]         shifted;
  logic [16:0]         diff;
  logic                fits;
  logic [31:0]         quo_ext;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[DivWidth-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = fits ? diff[15:0] : shifted[15:0];
      quo_d = {quo_q[DivWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntWidth'(DivWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.neg;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quo_ext        = {{(32 - DivWidth){1'b0}}, quo_q};
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (32'd0 - quo_ext) : quo_ext;

endmodule

### rtl/optical_flow_frame_decoder_top.sv
// optical flow frame decoder
// input channel: in_valid_i/in_ready_o, op_i selects a received uart byte (0)
// or a line-idle event (1) that closes the burst. bytes fill a 14-byte frame,
// extra bytes are dropped. byte transfers give no result.
// an idle transfer checks header, length, tail and byte count and gives one
// result on out_valid_o/out_ready_i: flow = integral*25600/time per axis.
// an idle event with a good frame and nonzero time runs through the shared
// radix-2 divider (30 steps per axis, x then y) before the result is moved
// into the output register; a bad frame or zero time goes straight to the
// done state.
// in_ready_o is low while a frame is decoded, so a good idle event holds the
// input until its decode is done. byte transfers are taken while a result
// waits; a finished decode holds until the output register is free, so a
// stalled receiver stalls the input only once the next decode is finished.
// reset clears the byte count, the held outputs and the output valid.
module optical_flow_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic        divide_fault_o,
  output logic signed [31:0] flow_x_o,
  output logic signed [31:0] flow_y_o,
  output logic [15:0] ground_dist_o,
  output logic [7:0]  sensor_valid_o,
  output logic [7:0]  confidence_o
);
  import ofd_pkg::*;

  state_e              state_q, state_d;
  logic [7:0]          store_q [FrameBytes];
  logic [PosWidth-1:0] pos_q;
  logic                ok_q, fault_q;
  logic [31:0]         qx_q, qy_q;
  logic                out_valid_q, out_ok_q, out_fault_q;
  logic [31:0]         held_x_q, held_y_q;
  logic [15:0]         held_dist_q;
  logic [7:0]          held_valid_q, held_conf_q;

  logic        in_fire, idle_fire, byte_fire, out_free;
  logic [15:0] int_x, int_y, int_t, opnd;
  logic        frame_good, time_zero;
  logic signed [32:0] prod;
  logic [32:0] prod_mag;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign idle_fire  = in_fire & (op_e'(op_i) == OpIdle);
  assign byte_fire  = in_fire & (op_e'(op_i) == OpByte);
  assign out_free   = ~out_valid_q | out_ready_i;

  assign int_x = {store_q[3], store_q[2]};
  assign int_y = {store_q[5], store_q[4]};
  assign int_t = {store_q[7], store_q[6]};

  assign frame_good = (pos_q == PosWidth'(FrameBytes)) && (store_q[0] == HdrByte)
                   && (store_q[1] == LenByte) && (store_q[13] == TailByte);
  assign time_zero  = (int_t == 16'd0);

  // shared scale multiplier feeding the divider
  assign opnd     = (state_q == StDivX) ? int_y : int_x;
  assign prod     = $signed(opnd) * $signed({1'b0, FlowScale});
  assign prod_mag = prod[32] ? (33'd0 - prod) : prod;

  assign div_req.start    = (idle_fire & frame_good & ~time_zero)
                          | ((state_q == StDivX) & div_rsp.done);
  assign div_req.neg      = prod[32];
  assign div_req.dividend = prod_mag[DivWidth-1:0];
  assign div_req.divisor  = int_t;

  ofd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (idle_fire) begin
          state_d = (frame_good & ~time_zero) ? StDivX : StDone;
        end
      end
      StDivX: begin
        if (div_rsp.done) begin
          state_d = StDivY;
        end
      end
      StDivY: begin
        if (div_rsp.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_dist_q  <= '0;
      held_valid_q <= '0;
      held_conf_q  <= '0;
    end else begin
      state_q <= state_d;
      if (idle_fire) begin
        pos_q <= '0;
      end else if (byte_fire && (pos_q < PosWidth'(FrameBytes))) begin
        pos_q <= pos_q + 1'b1;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
        if (ok_q) begin
          held_x_q     <= fault_q ? 32'd0 : qx_q;
          held_y_q     <= fault_q ? 32'd0 : qy_q;
          held_dist_q  <= {store_q[9], store_q[8]};
          held_valid_q <= store_q[10];
          held_conf_q  <= store_q[11];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire && (pos_q < PosWidth'(FrameBytes))) begin
      store_q[pos_q[PosWidth-1:0]] <= rx_byte_i;
    end
    if (idle_fire) begin
      ok_q    <= frame_good;
      fault_q <= frame_good & time_zero;
    end
    if ((state_q == StDivX) && div_rsp.done) begin
      qx_q <= div_rsp.quotient;
    end
    if ((state_q == StDivY) && div_rsp.done) begin
      qy_q <= div_rsp.quotient;
    end
    if ((state_q == StDone) && out_free) begin
      out_ok_q    <= ok_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ok_o     = out_ok_q;
  assign divide_fault_o = out_fault_q;
  assign flow_x_o       = held_x_q;
  assign flow_y_o       = held_y_q;
  assign ground_dist_o  = held_dist_q;
  assign sensor_valid_o = held_valid_q;
  assign confidence_o   = held_conf_q;

endmodule

### rtl/ofd_checker.sv
module ofd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_ok_o,
  input logic        divide_fault_o,
  input logic [31:0] flow_x_o,
  input logic [31:0] flow_y_o
);

  // a pending result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_ok_o) && $stable(flow_x_o))
    else $error("result dropped or changed while stalled");

  // no result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a divide fault only on a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> frame_ok_o)
    else $error("divide fault on a bad frame");

  // a divide fault gives zero flow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> (flow_x_o == 32'd0) && (flow_y_o == 32'd0))
    else $error("nonzero flow with divide fault");

endmodule

bind optical_flow_frame_decoder_top ofd_checker u_ofd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_ok_o     (frame_ok_o),
  .divide_fault_o (divide_fault_o),
  .flow_x_o       (flow_x_o),
  .flow_y_o       (flow_y_o)
);
